// ===== rtl/core/pspd_pkg.sv =====
package pspd_pkg;

  localparam int MAX_ITEMS_DEF      = 64;
  localparam int DATA_W             = 32;
  localparam int POS_W              = 6;
  localparam int SHORT_PERIOD_LIMIT = 4;

  typedef struct packed {
    logic signed [DATA_W-1:0] item_first;
    logic signed [DATA_W-1:0] item_second;
    logic                     item_last;
  } item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] entry_first;
    logic signed [DATA_W-1:0] entry_second;
    logic                     entry_valid;
    logic                     fully_periodic;
    logic [POS_W-1:0]         mismatch_position;
    logic                     overflowed;
    logic                     result_last;
  } result_t;

  typedef enum logic [3:0] {
    S_LOAD,
    S_FIND_RD,
    S_FIND_CMP,
    S_VER_RD,
    S_VER_CMP,
    S_DECIDE,
    S_EMIT_RD,
    S_EMIT_WR,
    S_STATUS
  } state_t;

  typedef struct packed {
    logic load;         // store the transferred item
    logic find_init;    // start the period search
    logic rd_find;      // read pair idx against pair zero
    logic find_next;
    logic set_period;
    logic rd_ver;       // read pair idx against pair idx mod period
    logic ver_next;
    logic set_fail;
    logic decide;       // apply the short-period forgiveness
    logic rd_emit;
    logic emit_next;
    logic load_entry;
    logic load_status;
    logic finish;       // empty the store for the next run
  } cmd_t;

  typedef struct packed {
    logic idx_end;
    logic pair_eq;
    logic out_free;
    logic drop;
    logic emit_end;
  } sts_t;

endpackage

// ===== rtl/core/pair_sequence_period_detect_top.sv =====
// Collects pairs until one arrives with item_last set, then finds the period
// (first later pair equal to pair zero), checks the whole sequence against it
// and returns either the period's pairs (one result each, result_last on the
// final one) or a single status result. item_ready is high only while loading,
// so no new pair is taken while a run is under way. Each comparison in the
// period search and in the check is a registered read of the pair store
// followed by a compare; a decide step then closes the check. Each emitted entry
// is a registered read followed by a load of the output register, which waits
// while a held result has not been taken. Pairs beyond MAX_ITEMS are dropped
// and reported through overflowed.
// keep_on_mismatch may be written only while idle.
module pair_sequence_period_detect_top #(
  parameter int MAX_ITEMS = pspd_pkg::MAX_ITEMS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  pspd_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_ready,
  output pspd_pkg::result_t result,
  input  logic              cfg_wr_en,
  input  logic              cfg_wr_data
);
  import pspd_pkg::*;

  cmd_t cmd;
  sts_t sts;

  pspd_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_last  (item.item_last),
    .item_ready (item_ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  pspd_dpath #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .cmd          (cmd),
    .sts          (sts),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

// ===== rtl/core/pspd_ctrl.sv =====
module pspd_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          item_valid,
  input  logic          item_last,
  output logic          item_ready,
  input  pspd_pkg::sts_t sts,
  output pspd_pkg::cmd_t cmd
);
  import pspd_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_LOAD: begin
        if (item_valid && item_last) state_next = S_FIND_RD;
      end
      S_FIND_RD: begin
        state_next = sts.idx_end ? S_STATUS : S_FIND_CMP;
      end
      S_FIND_CMP: begin
        state_next = sts.pair_eq ? S_VER_RD : S_FIND_RD;
      end
      S_VER_RD: begin
        state_next = sts.idx_end ? S_DECIDE : S_VER_CMP;
      end
      S_VER_CMP: begin
        state_next = sts.pair_eq ? S_VER_RD : S_DECIDE;
      end
      S_DECIDE: begin
        state_next = sts.drop ? S_STATUS : S_EMIT_RD;
      end
      S_EMIT_RD: begin
        state_next = S_EMIT_WR;
      end
      S_EMIT_WR: begin
        if (sts.out_free) state_next = sts.emit_end ? S_LOAD : S_EMIT_RD;
      end
      S_STATUS: begin
        if (sts.out_free) state_next = S_LOAD;
      end
      default: state_next = S_LOAD;
    endcase
  end

  always_comb begin
    cmd        = '0;
    item_ready = 1'b0;
    case (state)
      S_LOAD: begin
        item_ready    = 1'b1;
        cmd.load      = item_valid;
        cmd.find_init = item_valid && item_last;
      end
      S_FIND_RD: begin
        cmd.rd_find = !sts.idx_end;
      end
      S_FIND_CMP: begin
        cmd.set_period = sts.pair_eq;
        cmd.find_next  = !sts.pair_eq;
      end
      S_VER_RD: begin
        cmd.rd_ver = !sts.idx_end;
      end
      S_VER_CMP: begin
        cmd.ver_next = sts.pair_eq;
        cmd.set_fail = !sts.pair_eq;
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
      end
      S_EMIT_RD: begin
        cmd.rd_emit = 1'b1;
      end
      S_EMIT_WR: begin
        cmd.load_entry = sts.out_free;
        cmd.emit_next  = sts.out_free && !sts.emit_end;
        cmd.finish     = sts.out_free && sts.emit_end;
      end
      S_STATUS: begin
        cmd.load_status = sts.out_free;
        cmd.finish      = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ===== rtl/core/pspd_dpath.sv =====
module pspd_dpath #(
  parameter int MAX_ITEMS = pspd_pkg::MAX_ITEMS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  pspd_pkg::item_t   item,
  input  logic              cfg_wr_en,
  input  logic              cfg_wr_data,
  input  pspd_pkg::cmd_t    cmd,
  output pspd_pkg::sts_t    sts,
  output logic              result_valid,
  input  logic              result_ready,
  output pspd_pkg::result_t result
);
  import pspd_pkg::*;

  localparam int AW = $clog2(MAX_ITEMS);
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int PW = 2 * DATA_W;

  logic [PW-1:0] mem [MAX_ITEMS];
  logic [PW-1:0] qa;
  logic [PW-1:0] qb;

  logic [CW-1:0] count;
  logic          overflow;
  logic          keep_on_mismatch;
  logic [CW-1:0] idx;
  logic [AW-1:0] jdx;
  logic [AW-1:0] period;
  logic [AW-1:0] fail;
  logic [AW-1:0] fail_eff;
  logic [CW-1:0] tail_pos;
  logic          store_full;
  logic [AW-1:0] addr_b;

  assign store_full = (count == CW'(MAX_ITEMS));
  assign addr_b     = cmd.rd_find ? '0 : jdx;

  always_ff @(posedge clk) begin
    if (cmd.load && !store_full) begin
      mem[count[AW-1:0]] <= {item.item_first, item.item_second};
    end
    if (cmd.rd_find || cmd.rd_ver || cmd.rd_emit) begin
      qa <= mem[idx[AW-1:0]];
    end
    if (cmd.rd_find || cmd.rd_ver) begin
      qb <= mem[addr_b];
    end
  end

  // A mismatch one period before the end is forgiven for short periods.
  assign tail_pos = count - CW'(period);
  always_comb begin
    fail_eff = fail;
    if ((CW'(fail) == tail_pos) && (int'(period) <= SHORT_PERIOD_LIMIT)) fail_eff = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count            <= '0;
      overflow         <= 1'b0;
      keep_on_mismatch <= 1'b0;
    end else begin
      if (cfg_wr_en) keep_on_mismatch <= cfg_wr_data;
      if (cmd.finish) begin
        count    <= '0;
        overflow <= 1'b0;
      end else if (cmd.load) begin
        if (store_full) begin
          overflow <= 1'b1;
        end else begin
          count <= count + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.find_init) begin
      idx  <= CW'(1);
      fail <= '0;
    end
    if (cmd.find_next || cmd.emit_next) idx <= idx + 1'b1;
    if (cmd.set_period) begin
      period <= idx[AW-1:0];
      idx    <= CW'(1);
      jdx    <= (idx == CW'(1)) ? '0 : AW'(1);
    end
    if (cmd.ver_next) begin
      idx <= idx + 1'b1;
      jdx <= (jdx == period - 1'b1) ? '0 : jdx + 1'b1;
    end
    if (cmd.set_fail) fail <= idx[AW-1:0];
    if (cmd.decide) begin
      fail <= fail_eff;
      idx  <= '0;
    end
  end

  assign sts.idx_end  = (idx >= count);
  assign sts.pair_eq  = (qa == qb);
  assign sts.out_free = !result_valid || result_ready;
  assign sts.drop     = (fail_eff != '0) && !keep_on_mismatch;
  assign sts.emit_end = (idx[AW-1:0] == period - 1'b1);

  // Output register: hold the result until the downstream transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.load_entry || cmd.load_status) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_entry) begin
      result.entry_first       <= qa[PW-1:DATA_W];
      result.entry_second      <= qa[DATA_W-1:0];
      result.entry_valid       <= 1'b1;
      result.fully_periodic    <= (fail == '0);
      result.mismatch_position <= POS_W'(fail);
      result.overflowed        <= overflow;
      result.result_last       <= sts.emit_end;
    end else if (cmd.load_status) begin
      result.entry_first       <= '0;
      result.entry_second      <= '0;
      result.entry_valid       <= 1'b0;
      result.fully_periodic    <= 1'b0;
      result.mismatch_position <= POS_W'(fail);
      result.overflowed        <= overflow;
      result.result_last       <= 1'b1;
    end
  end

endmodule

// ===== bench/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pspd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned SETTLE_CYCLES = 30;

  typedef enum int unsigned {
    V_WIDE,
    V_EDGE,
    V_NARROW
  } value_style_t;

  logic clk;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_ready;
  item_t item = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  result_t result;
  logic cfg_wr_en = 1'b0;
  logic cfg_wr_data = 1'b0;

  // pairs waiting to be driven, and period entries the block still owes us
  item_t pairs_to_send[$];
  result_t entries_due[$];

  // shadow copy of the block's sequence store and setting
  logic [DATA_W-1:0] seq_first[MAX_ITEMS_DEF];
  logic [DATA_W-1:0] seq_second[MAX_ITEMS_DEF];
  int unsigned seq_len = 0;
  logic seq_dropped = 1'b0;
  logic keep_setting = 1'b0;

  bit steady_flow = 1'b0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned send_gap = 0;
  int unsigned stall_left = 0;

  pair_sequence_period_detect_top dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item(item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (steady_flow) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic bit pairs_match(int unsigned a, int unsigned b);
    return seq_first[a] == seq_first[b] && seq_second[a] == seq_second[b];
  endfunction

  // store one transferred pair; on the closing pair, find the period and queue the entries
  function automatic void absorb_pair(item_t it);
    int unsigned period;
    int unsigned fail_at;
    result_t r;
    if (seq_len < MAX_ITEMS_DEF) begin
      seq_first[seq_len] = it.item_first;
      seq_second[seq_len] = it.item_second;
      seq_len++;
    end else begin
      seq_dropped = 1'b1;
    end
    if (!it.item_last) return;

    period = 0;
    for (int unsigned i = 1; i < seq_len; i++) begin
      if (pairs_match(i, 0)) begin
        period = i;
        break;
      end
    end

    r = '0;
    r.overflowed = seq_dropped;
    r.result_last = 1'b1;
    if (period == 0) begin
      entries_due.push_back(r);
    end else begin
      fail_at = 0;
      for (int unsigned i = 1; i < seq_len; i++) begin
        if (!pairs_match(i, i % period)) begin
          fail_at = i;
          break;
        end
      end
      // a short period that breaks exactly one period before the end still counts
      if (fail_at == seq_len - period && period <= SHORT_PERIOD_LIMIT) fail_at = 0;
      if (fail_at != 0 && !keep_setting) begin
        r.mismatch_position = fail_at[POS_W-1:0];
        entries_due.push_back(r);
      end else begin
        for (int unsigned i = 0; i < period; i++) begin
          r.entry_first = seq_first[i];
          r.entry_second = seq_second[i];
          r.entry_valid = 1'b1;
          r.fully_periodic = (fail_at == 0);
          r.mismatch_position = fail_at[POS_W-1:0];
          r.result_last = (i + 1 == period);
          entries_due.push_back(r);
        end
      end
    end
    seq_len = 0;
    seq_dropped = 1'b0;
  endfunction

  function automatic void check_entry(result_t got);
    result_t want;
    if (entries_due.size() == 0) begin
      $error("unexpected result transfer: %p", got);
      error_count++;
      return;
    end
    want = entries_due.pop_front();
    if (got.entry_first !== want.entry_first) begin
      $error("entry_first: expected %0d, got %0d", want.entry_first, got.entry_first);
      error_count++;
    end
    if (got.entry_second !== want.entry_second) begin
      $error("entry_second: expected %0d, got %0d", want.entry_second, got.entry_second);
      error_count++;
    end
    if (got.entry_valid !== want.entry_valid) begin
      $error("entry_valid: expected %0b, got %0b", want.entry_valid, got.entry_valid);
      error_count++;
    end
    if (got.fully_periodic !== want.fully_periodic) begin
      $error("fully_periodic: expected %0b, got %0b", want.fully_periodic, got.fully_periodic);
      error_count++;
    end
    if (got.mismatch_position !== want.mismatch_position) begin
      $error("mismatch_position: expected %0d, got %0d",
             want.mismatch_position, got.mismatch_position);
      error_count++;
    end
    if (got.overflowed !== want.overflowed) begin
      $error("overflowed: expected %0b, got %0b", want.overflowed, got.overflowed);
      error_count++;
    end
    if (got.result_last !== want.result_last) begin
      $error("result_last: expected %0b, got %0b", want.result_last, got.result_last);
      error_count++;
    end
  endfunction

  // sender: hold each pair until its transfer, then idle for a random gap
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      send_gap <= 0;
    end else if (!item_valid || item_ready) begin
      if (send_gap != 0) begin
        item_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pairs_to_send.size() != 0) begin
        item <= pairs_to_send.pop_front();
        item_valid <= 1'b1;
        send_gap <= pick_gap();
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // receiver: check result transfers, track pair transfers, stall at random
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (result_valid && result_ready) check_entry(result);
      if (item_valid && item_ready) absorb_pair(item);
      if (stall_left != 0) begin
        result_ready <= 1'b0;
        stall_left <= stall_left - 1;
      end else if (!steady_flow && $urandom_range(0, 3) == 0) begin
        result_ready <= 1'b0;
        stall_left <= pick_gap();
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic logic [DATA_W-1:0] pick_value(value_style_t style);
    case (style)
      V_WIDE: return $urandom();
      V_EDGE: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      default: return $urandom_range(0, 2);
    endcase
  endfunction

  function automatic void queue_pair(logic [DATA_W-1:0] f, logic [DATA_W-1:0] s, logic last);
    item_t it;
    it.item_first = f;
    it.item_second = s;
    it.item_last = last;
    pairs_to_send.push_back(it);
  endfunction

  // one sequence: mostly a repeated period with random content, some with a flaw,
  // some plain noise, a few long enough to fill or overrun the store
  function automatic int unsigned queue_random_run();
    logic [DATA_W-1:0] base_f[MAX_ITEMS_DEF];
    logic [DATA_W-1:0] base_s[MAX_ITEMS_DEF];
    logic [DATA_W-1:0] f;
    logic [DATA_W-1:0] s;
    int unsigned shape, length, kept, cap, period, kind, flaw_at, roll;
    value_style_t style;
    shape = $urandom_range(0, 99);
    if (shape < 4) length = $urandom_range(MAX_ITEMS_DEF + 1, MAX_ITEMS_DEF + 8);
    else if (shape < 9) length = $urandom_range(30, MAX_ITEMS_DEF);
    else length = $urandom_range(1, 12);
    kept = (length > MAX_ITEMS_DEF) ? MAX_ITEMS_DEF : length;
    cap = (kept > 1) ? kept - 1 : 1;

    roll = $urandom_range(0, 99);
    if (roll < 70) period = $urandom_range(1, (cap < 4) ? cap : 4);
    else if (roll < 95) period = $urandom_range(1, (cap < 8) ? cap : 8);
    else period = $urandom_range(1, (cap < 20) ? cap : 20);

    roll = $urandom_range(0, 99);
    if (roll < 70) style = V_WIDE;
    else if (roll < 85) style = V_EDGE;
    else style = V_NARROW;
    for (int unsigned i = 0; i < period; i++) begin
      base_f[i] = pick_value(style);
      base_s[i] = pick_value(style);
    end

    kind = $urandom_range(0, 99);
    flaw_at = 0;
    if (kind >= 20 && kind < 55 && kept >= period + 2) begin
      if ($urandom_range(0, 1) == 1 && kept >= 2 * period + 1) flaw_at = kept - period;
      else flaw_at = $urandom_range(period + 1, kept - 1);
    end

    for (int unsigned i = 0; i < length; i++) begin
      if (kind < 20) begin
        f = pick_value(V_NARROW);
        s = pick_value(V_NARROW);
      end else begin
        f = base_f[i % period];
        s = base_s[i % period];
        if (flaw_at != 0 && i == flaw_at) begin
          if ($urandom_range(0, 1) == 1) f[$urandom_range(0, DATA_W - 1)] ^= 1'b1;
          else s[$urandom_range(0, DATA_W - 1)] ^= 1'b1;
        end
      end
      queue_pair(f, s, i == length - 1);
    end
    return length;
  endfunction

  // wait until every pair is sent and every entry has come back, then let the block settle
  task automatic drain();
    do @(negedge clk);
    while (pairs_to_send.size() != 0 || item_valid || entries_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_keep(logic value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    keep_setting = value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    int unsigned queued;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    write_keep(1'b0);

    // a lone pair: no period
    queue_pair(32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
    // period of one
    queue_pair(32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
    queue_pair(32'hFFFF_FFFF, 32'h0000_0000, 1'b1);
    // pairs that differ in one half only: still no period
    queue_pair(32'd1, 32'd2, 1'b0);
    queue_pair(32'd1, 32'd3, 1'b0);
    queue_pair(32'd2, 32'd2, 1'b1);
    // period two, broken one period before the end: forgiven
    queue_pair(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
    queue_pair(32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
    queue_pair(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
    queue_pair(32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
    queue_pair(32'h7FFF_FFFF, 32'h8000_0001, 1'b0);
    queue_pair(32'h0000_0000, 32'hFFFF_FFFF, 1'b1);
    // period five broken at the same spot: too long to be forgiven
    for (int unsigned i = 0; i < 11; i++) begin
      if (i == 6) queue_pair(32'd11, 32'h7FFF_FFFF, i == 10);
      else queue_pair(32'd10 + (i % 5), 32'hFFFF_FFF0 - (i % 5), i == 10);
    end
    drain();

    for (int unsigned phase = 0; phase < 5; phase++) begin
      write_keep(phase % 2 == 0);
      steady_flow = (phase == 2);
      queued = 0;
      while (queued < 80) queued += queue_random_run();
      drain();
    end

    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
